// File: design/srfes_pkg.sv
// Shared types and constants for the serial receive FIFO with error statistics.
// Holds item kinds, datapath operations, counter indices and the command/status structs.
// No dependencies.
`default_nettype none
package srfes_pkg;

    // item kinds, carried in tuser
    localparam logic [2:0] KIND_RX        = 3'd0;
    localparam logic [2:0] KIND_POP       = 3'd1;
    localparam logic [2:0] KIND_CLR_BUF   = 3'd2;
    localparam logic [2:0] KIND_SENT      = 3'd3;
    localparam logic [2:0] KIND_CLR_STATS = 3'd4;

    // statistics counter slots
    localparam int CNT_RECEIVED = 0;
    localparam int CNT_DROPPED  = 1;
    localparam int CNT_OVERRUN  = 2;
    localparam int CNT_FRAMING  = 3;
    localparam int CNT_NOISE    = 4;
    localparam int CNT_PARITY   = 5;
    localparam int CNT_SENT     = 6;
    localparam int NUM_CNT      = 7;

    // fixed field widths
    localparam int KIND_W   = 3;
    localparam int ERR_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int OCC_W    = 8;
    localparam int REPORT_W = 32;

    localparam int IN_BITS      = ERR_W + 1 + BYTE_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = BYTE_W + 1 + OCC_W + NUM_CNT * REPORT_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_BITS;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ERRS,
        OP_STORE,
        OP_DROP,
        OP_POP,
        OP_POP_EMPTY,
        OP_CLR_BUF,
        OP_SENT,
        OP_CLR_STATS
    } t_op;

    typedef struct packed {
        logic capture;  // take the input word into the item register
        logic exec;     // apply op to pointers, store and counters
        t_op  op;
        logic load;     // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              err_any;
        logic              byte_ready;
        logic              full;
        logic              empty;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: design/srfes_ctrl.sv
// Controller: sequences one item through capture, execute and result load.
// Decodes the item kind and buffer status into a datapath operation. Uses srfes_pkg.
`default_nettype none
module srfes_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    input  wire srfes_pkg::t_dp_stat i_stat,
    output srfes_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    srfes_pkg::t_op op;

    always_comb begin
        op = srfes_pkg::OP_NONE;
        unique case (i_stat.kind)
            srfes_pkg::KIND_RX: begin
                if (i_stat.err_any) begin
                    op = srfes_pkg::OP_ERRS;
                end else if (i_stat.byte_ready) begin
                    op = i_stat.full ? srfes_pkg::OP_DROP : srfes_pkg::OP_STORE;
                end
            end
            srfes_pkg::KIND_POP: begin
                op = i_stat.empty ? srfes_pkg::OP_POP_EMPTY : srfes_pkg::OP_POP;
            end
            srfes_pkg::KIND_CLR_BUF:   op = srfes_pkg::OP_CLR_BUF;
            srfes_pkg::KIND_SENT:      op = srfes_pkg::OP_SENT;
            srfes_pkg::KIND_CLR_STATS: op = srfes_pkg::OP_CLR_STATS;
            default:                   op = srfes_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.op      = op;
        o_cmd.load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // wait here only while the previous result is still unclaimed
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: design/srfes_datapath.sv
// Datapath: item register, ring buffer store and pointers, statistics counters
// and the result register. Driven by srfes_ctrl commands; uses srfes_pkg.
`default_nettype none
module srfes_datapath #(
    parameter int BUFFER_DEPTH  = 256,
    parameter int COUNTER_WIDTH = 32
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire  [srfes_pkg::KIND_W-1:0]            i_kind,
    input  wire  [srfes_pkg::ERR_W-1:0]             i_error_bits,
    input  wire                                     i_byte_ready,
    input  wire  [srfes_pkg::BYTE_W-1:0]            i_data_in,
    input  wire  srfes_pkg::t_dp_cmd                i_cmd,
    output srfes_pkg::t_dp_stat                     o_stat,
    output logic [srfes_pkg::OUT_TDATA_W-1:0]       o_word
);

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW    = PTR_W + 1;
    localparam int EXT_W = (CW > srfes_pkg::OCC_W) ? CW : srfes_pkg::OCC_W;
    localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0]    DEPTH_CNT = CW'(BUFFER_DEPTH);
    localparam logic [EXT_W-1:0] OCC_MAX   = EXT_W'(255);

    logic [srfes_pkg::KIND_W-1:0] r_kind;
    logic [srfes_pkg::ERR_W-1:0]  r_errs;
    logic                         r_rdy;
    logic [srfes_pkg::BYTE_W-1:0] r_data;

    logic [srfes_pkg::BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [srfes_pkg::BYTE_W-1:0] r_rd_data;
    logic [PTR_W-1:0]             r_wp, r_rp;
    logic                         r_pop_ok, r_pop_empty;

    logic [COUNTER_WIDTH-1:0]     r_cnt [srfes_pkg::NUM_CNT];
    logic [srfes_pkg::NUM_CNT-1:0] bump;

    logic [CW-1:0]                held;
    logic [EXT_W-1:0]             held_ext;
    logic [srfes_pkg::OCC_W-1:0]  occ;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_errs <= i_error_bits;
            r_rdy  <= i_byte_ready;
            r_data <= i_data_in;
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.err_any    = |r_errs;
    assign o_stat.byte_ready = r_rdy;
    assign o_stat.full       = (adv(r_wp) == r_rp);
    assign o_stat.empty      = (r_wp == r_rp);

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && i_cmd.op == srfes_pkg::OP_STORE) begin
            mem[r_wp] <= r_data;
        end
        if (i_cmd.exec) begin
            r_rd_data   <= mem[r_rp];
            r_pop_ok    <= (i_cmd.op == srfes_pkg::OP_POP);
            r_pop_empty <= (i_cmd.op == srfes_pkg::OP_POP_EMPTY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else if (i_cmd.exec) begin
            case (i_cmd.op)
                srfes_pkg::OP_STORE:   r_wp <= adv(r_wp);
                srfes_pkg::OP_POP:     r_rp <= adv(r_rp);
                srfes_pkg::OP_CLR_BUF: begin
                    r_wp <= '0;
                    r_rp <= '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        bump = '0;
        if (i_cmd.exec) begin
            case (i_cmd.op)
                srfes_pkg::OP_ERRS: begin
                    bump[srfes_pkg::CNT_OVERRUN] = r_errs[0];
                    bump[srfes_pkg::CNT_FRAMING] = r_errs[1];
                    bump[srfes_pkg::CNT_NOISE]   = r_errs[2];
                    bump[srfes_pkg::CNT_PARITY]  = r_errs[3];
                end
                srfes_pkg::OP_STORE: bump[srfes_pkg::CNT_RECEIVED] = 1'b1;
                srfes_pkg::OP_DROP:  bump[srfes_pkg::CNT_DROPPED]  = 1'b1;
                srfes_pkg::OP_SENT:  bump[srfes_pkg::CNT_SENT]     = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.exec && i_cmd.op == srfes_pkg::OP_CLR_STATS)) begin
            for (int i = 0; i < srfes_pkg::NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            for (int i = 0; i < srfes_pkg::NUM_CNT; i++) begin
                if (bump[i]) begin
                    r_cnt[i] <= r_cnt[i] + 1'b1;
                end
            end
        end
    end

    // occupancy after the item, saturating at 255 for deep buffers
    always_comb begin
        if (r_wp >= r_rp) begin
            held = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            held = DEPTH_CNT - {1'b0, r_rp} + {1'b0, r_wp};
        end
        held_ext = EXT_W'(held);
        occ = (held_ext > OCC_MAX) ? OCC_MAX[srfes_pkg::OCC_W-1:0]
                                   : held_ext[srfes_pkg::OCC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_word <= {{srfes_pkg::OUT_PAD_W{1'b0}},
                       srfes_pkg::REPORT_W'(r_cnt[srfes_pkg::CNT_SENT]),
                       srfes_pkg::REPORT_W'(r_cnt[srfes_pkg::CNT_PARITY]),
                       srfes_pkg::REPORT_W'(r_cnt[srfes_pkg::CNT_NOISE]),
                       srfes_pkg::REPORT_W'(r_cnt[srfes_pkg::CNT_FRAMING]),
                       srfes_pkg::REPORT_W'(r_cnt[srfes_pkg::CNT_OVERRUN]),
                       srfes_pkg::REPORT_W'(r_cnt[srfes_pkg::CNT_DROPPED]),
                       srfes_pkg::REPORT_W'(r_cnt[srfes_pkg::CNT_RECEIVED]),
                       occ,
                       r_pop_empty,
                       r_pop_ok ? r_rd_data : {srfes_pkg::BYTE_W{1'b0}}};
        end
    end

endmodule
`default_nettype wire

// File: design/serial_receive_fifo_with_error_stats.sv
// Top level: serial receive ring buffer with error statistics.
// Instantiates srfes_ctrl and srfes_datapath; uses srfes_pkg.
//
//  channel   | direction | handshake                     | carries
//  ----------+-----------+-------------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | receive event or command word
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | read result, occupancy, counters
//
// Each word passes through capture, execute (pointer, counter and store update with a
// registered store read), then load of the result register.
// A new word is taken while the previous result waits in the result register; the load
// step holds until that register is free.
// Synchronous active-low reset clears pointers, counters and handshake state; the store
// itself is not cleared.
`default_nettype none
module serial_receive_fifo_with_error_stats #(
    parameter int BUFFER_DEPTH  = 256,
    parameter int COUNTER_WIDTH = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] error_bits, [4] byte_ready, [12:5] data_in, rest zero
    input  wire  [srfes_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] kind
    input  wire  [srfes_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [7:0] read_data, [8] read_status, [16:9] occupancy, [48:17] received_count,
    // [80:49] dropped_count, [112:81] overrun_count, [144:113] framing_count,
    // [176:145] noise_count, [208:177] parity_count, [240:209] sent_count, rest zero
    output logic [srfes_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    srfes_pkg::t_dp_cmd  cmd;
    srfes_pkg::t_dp_stat stat;

    srfes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    srfes_datapath #(
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kind       (s_axis_tuser),
        .i_error_bits (s_axis_tdata[3:0]),
        .i_byte_ready (s_axis_tdata[4]),
        .i_data_in    (s_axis_tdata[12:5]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_word       (m_axis_tdata)
    );

    // accepted word is executed on the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> cmd.exec)
        else $error("accepted word not executed");

    // no new word while an item is in execute or waiting to load
    a_exec_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> !s_axis_tready)
        else $error("ready during item processing");

    // a loaded result is presented
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // result register never overwritten while its word is still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before transfer");

endmodule
`default_nettype wire
